// ===== src/gae_pkg.sv =====
// Shared types and codes for the graph adjacency engine.
package gae_pkg;

    localparam int unsigned VertexIdWidth = 10;
    localparam int unsigned CountWidth    = 11;
    localparam int unsigned ModeWidth     = 3;
    localparam int unsigned AnswerWidth   = 14;
    localparam int unsigned StatusWidth   = 3;

    localparam logic [ModeWidth-1:0] MODE_ADD    = 3'd0;
    localparam logic [ModeWidth-1:0] MODE_BUILD  = 3'd1;
    localparam logic [ModeWidth-1:0] MODE_ADJ    = 3'd2;
    localparam logic [ModeWidth-1:0] MODE_COMMON = 3'd3;
    localparam logic [ModeWidth-1:0] MODE_CLEAR  = 3'd4;

    localparam logic [StatusWidth-1:0] ST_OK      = 3'd0;
    localparam logic [StatusWidth-1:0] ST_RANGE   = 3'd1;
    localparam logic [StatusWidth-1:0] ST_LOOP    = 3'd2;
    localparam logic [StatusWidth-1:0] ST_FULL    = 3'd3;
    localparam logic [StatusWidth-1:0] ST_UNBUILT = 3'd4;

    typedef struct packed {
        logic [ModeWidth-1:0]     mode;
        logic [VertexIdWidth-1:0] vertex_a;
        logic [VertexIdWidth-1:0] vertex_b;
    } gae_in_t;

    typedef struct packed {
        logic [AnswerWidth-1:0] answer;
        logic [StatusWidth-1:0] status;
    } gae_out_t;

endpackage

// ===== src/graph_adjacency_engine_unit.sv =====
// Top level of the graph adjacency engine: sequencer and its memories.
//
//   channel | ports              | direction | payload
//   --------+--------------------+-----------+-----------------------------------
//   input   | s_valid/s_ready    | in        | gae_in_t  (mode, vertex_a, vertex_b)
//   result  | m_valid/m_ready    | out       | gae_out_t (answer, status)
//   config  | cfg_valid/cfg_ready| in        | vertex_count, 11 bits
//
// One item is worked at a time. Build zeroes the degrees, counts both
// endpoints of every usable stored edge, forms the prefix sum of the degrees
// into offsets and then scatters both endpoints into the neighbor lists; each
// memory has one port and the read-modify-write of degree counts sets the pace.
// An adjacency query walks the shorter neighbor list (vertex_b's on a tie), and
// a common-neighbor query marks the neighbors of vertex_a, counts marks over the
// list of vertex_b and clears the marks again. Reset is synchronous and active
// low; it clears control state and is followed by a clearing pass over every
// mark memory entry, with the input held off. A waiting result does not block
// the input: the next item is taken and worked, and only its own result waits
// for the output register.
module graph_adjacency_engine_unit
    import gae_pkg::*;
#(
    parameter int unsigned MAX_VERTICES = 1024,
    parameter int unsigned MAX_EDGES    = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  gae_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output gae_out_t              m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CountWidth-1:0] cfg_data
);

    localparam int unsigned VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int unsigned VCW = $clog2(MAX_VERTICES + 1);
    localparam int unsigned EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int unsigned ECW = $clog2(MAX_EDGES + 1);
    localparam int unsigned NW = $clog2(2 * MAX_EDGES + 1);
    localparam int unsigned NAW = $clog2(2 * MAX_EDGES);
    localparam int unsigned IW = (VCW > ECW) ? VCW : ECW;

    typedef enum logic [17:0] {
        S_IDLE    = 18'h00001,
        S_BZERO   = 18'h00002,
        S_BCNT_RD = 18'h00004,
        S_BCNT_W  = 18'h00008,
        S_BCNT_WB = 18'h00010,
        S_BPFX_RD = 18'h00020,
        S_BPFX_W  = 18'h00040,
        S_BSC_RD  = 18'h00080,
        S_BSC_W   = 18'h00100,
        S_BSC_WB  = 18'h00200,
        S_Q_RD    = 18'h00400,
        S_Q_ADDR  = 18'h00800,
        S_Q_NRD   = 18'h01000,
        S_Q_NCHK  = 18'h02000,
        S_DONE    = 18'h04000,
        S_Q_PHASE = 18'h08000,
        S_CLR     = 18'h10000,
        S_Q_MCHK  = 18'h20000
    } state_t;

    // Memories; degree and offset memories share one address per vertex.
    logic [2*VW-1:0] edge_mem [MAX_EDGES];
    logic [NW-1:0]   deg_mem  [MAX_VERTICES];
    logic [NW-1:0]   off_mem  [MAX_VERTICES];
    logic [VW-1:0]   nbr_mem  [2*MAX_EDGES];
    logic            mark_mem [MAX_VERTICES];

    state_t                 state_reg, state_next;
    logic [ECW-1:0]         edge_total_reg;
    logic                   built_reg;
    logic [CountWidth-1:0]  vcount_reg;
    logic                   busy_reg;
    gae_in_t                item_reg;
    logic                   out_valid_reg;
    gae_out_t               out_reg;
    gae_out_t               work_reg;

    logic [IW-1:0]          idx_reg;      // vertex or edge index walk
    logic [NW-1:0]          sum_reg;
    logic [1:0]             half_reg;     // endpoint select / query phase
    logic [2*VW-1:0]        edge_rd_reg;
    logic [NW-1:0]          deg_rd_reg;
    logic [NW-1:0]          off_rd_reg;
    logic [VW-1:0]          nbr_rd_reg;
    logic                   mark_rd_reg;
    logic [NW-1:0]          base_reg, len_reg, pos_reg;
    logic [VW-1:0]          target_reg;
    logic [AnswerWidth-1:0] count_reg;
    logic                   deg_a_valid_reg;
    logic [NW-1:0]          deg_a_reg, off_a_reg;

    // Effective vertex count, saturated to 1..MAX_VERTICES.
    logic [VCW-1:0] vc;
    always_comb begin
        if (vcount_reg == '0) begin
            vc = VCW'(1);
        end else if (32'(vcount_reg) > MAX_VERTICES) begin
            vc = VCW'(MAX_VERTICES);
        end else begin
            vc = VCW'(vcount_reg);
        end
    end

    wire logic [VW-1:0] ea = edge_rd_reg[VW-1:0];
    wire logic [VW-1:0] eb = edge_rd_reg[2*VW-1:VW];
    wire logic edge_ok = (VCW'(ea) < vc) && (VCW'(eb) < vc) && (ea != eb);
    wire logic a_in = 32'(item_reg.vertex_a) < 32'(vc);
    wire logic b_in = 32'(item_reg.vertex_b) < 32'(vc);

    assign s_ready   = !busy_reg;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    // Memory ports driven by the sequencer.
    logic            deg_we, off_we, nbr_we, edge_we, mark_we;
    logic [VW-1:0]   deg_addr;
    logic [NW-1:0]   deg_wdata, off_wdata;
    logic [NAW-1:0]  nbr_addr;
    logic [VW-1:0]   nbr_wdata;
    logic [EW-1:0]   edge_addr;
    logic [VW-1:0]   mark_addr;
    logic            mark_wdata;

    always_ff @(posedge aclk) begin
        if (edge_we) begin
            edge_mem[edge_addr] <= {VW'(item_reg.vertex_b), VW'(item_reg.vertex_a)};
        end
        edge_rd_reg <= edge_mem[edge_addr];
        if (deg_we) begin
            deg_mem[deg_addr] <= deg_wdata;
        end
        deg_rd_reg <= deg_mem[deg_addr];
        if (off_we) begin
            off_mem[deg_addr] <= off_wdata;
        end
        off_rd_reg <= off_mem[deg_addr];
        if (nbr_we) begin
            nbr_mem[nbr_addr] <= nbr_wdata;
        end
        nbr_rd_reg <= nbr_mem[nbr_addr];
        if (mark_we) begin
            mark_mem[mark_addr] <= mark_wdata;
        end
        mark_rd_reg <= mark_mem[mark_addr];
    end

    // Sequencer.
    logic [NW-1:0] deg_inc;
    assign deg_inc = deg_rd_reg + NW'(1);

    always_comb begin
        state_next = state_reg;
        deg_we = 1'b0; off_we = 1'b0; nbr_we = 1'b0; edge_we = 1'b0; mark_we = 1'b0;
        deg_addr = VW'(idx_reg);
        deg_wdata = '0;
        off_wdata = sum_reg;
        nbr_addr = NAW'(pos_reg);
        nbr_wdata = target_reg;
        edge_addr = EW'(idx_reg);
        mark_addr = nbr_rd_reg;
        mark_wdata = 1'b0;
        case (state_reg)
            S_CLR: begin
                // The mark memory must read clear before the first query.
                mark_addr = VW'(idx_reg);
                mark_we = 1'b1;
                if (32'(idx_reg) + 1 >= MAX_VERTICES) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (busy_reg) begin
                    case (item_reg.mode)
                        MODE_ADD: begin
                            edge_addr = EW'(edge_total_reg);
                            edge_we = a_in && b_in && (item_reg.vertex_a != item_reg.vertex_b)
                                      && (32'(edge_total_reg) < MAX_EDGES);
                            state_next = S_DONE;
                        end
                        MODE_BUILD: state_next = S_BZERO;
                        MODE_ADJ, MODE_COMMON: begin
                            if (a_in && b_in && built_reg) begin
                                state_next = S_Q_RD;
                            end else begin
                                state_next = S_DONE;
                            end
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_BZERO: begin
                deg_addr = VW'(idx_reg);
                deg_we = 1'b1;
                if (32'(idx_reg) + 1 >= 32'(vc)) begin
                    state_next = S_BCNT_RD;
                end
            end
            S_BCNT_RD: begin
                if (32'(idx_reg) >= 32'(edge_total_reg)) begin
                    state_next = S_BPFX_RD;
                end else begin
                    state_next = S_BCNT_W;
                end
            end
            S_BCNT_W: begin
                deg_addr = half_reg[0] ? eb : ea;
                if (!edge_ok) begin
                    state_next = S_BCNT_RD;
                end else begin
                    state_next = S_BCNT_WB;
                end
            end
            S_BCNT_WB: begin
                deg_addr = half_reg[0] ? eb : ea;
                deg_we = 1'b1;
                deg_wdata = deg_inc;
                if (half_reg[0]) begin
                    state_next = S_BCNT_RD;
                end else begin
                    state_next = S_BCNT_W;
                end
            end
            S_BPFX_RD: begin
                deg_addr = VW'(idx_reg);
                state_next = S_BPFX_W;
            end
            S_BPFX_W: begin
                deg_addr = VW'(idx_reg);
                deg_we = 1'b1;
                off_we = 1'b1;
                if (32'(idx_reg) + 1 >= 32'(vc)) begin
                    state_next = S_BSC_RD;
                end else begin
                    state_next = S_BPFX_RD;
                end
            end
            S_BSC_RD: begin
                if (32'(idx_reg) >= 32'(edge_total_reg)) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_BSC_W;
                end
            end
            S_BSC_W: begin
                deg_addr = half_reg[0] ? eb : ea;
                if (!edge_ok) begin
                    state_next = S_BSC_RD;
                end else begin
                    state_next = S_BSC_WB;
                end
            end
            S_BSC_WB: begin
                deg_addr = half_reg[0] ? eb : ea;
                deg_we = 1'b1;
                deg_wdata = deg_inc;
                nbr_we = 1'b1;
                nbr_addr = NAW'(off_rd_reg + deg_rd_reg);
                nbr_wdata = half_reg[0] ? ea : eb;
                if (half_reg[0]) begin
                    state_next = S_BSC_RD;
                end else begin
                    state_next = S_BSC_W;
                end
            end
            S_Q_RD: begin
                // Read degree and offset of vertex_a, then vertex_b.
                deg_addr = deg_a_valid_reg ? VW'(item_reg.vertex_b) : VW'(item_reg.vertex_a);
                state_next = S_Q_ADDR;
            end
            S_Q_ADDR: begin
                if (!deg_a_valid_reg) begin
                    state_next = S_Q_RD;
                end else begin
                    state_next = S_Q_PHASE;
                end
            end
            S_Q_PHASE: begin
                if (pos_reg >= len_reg) begin
                    if (item_reg.mode == MODE_COMMON && half_reg != 2'd3) begin
                        state_next = S_Q_PHASE;
                    end else begin
                        state_next = S_DONE;
                    end
                end else begin
                    nbr_addr = NAW'(base_reg + pos_reg);
                    state_next = S_Q_NRD;
                end
            end
            S_Q_NRD: begin
                // Hold the neighbor address so the fetched entry stays in place.
                nbr_addr = NAW'(base_reg + pos_reg);
                state_next = S_Q_NCHK;
            end
            S_Q_NCHK: begin
                if (item_reg.mode == MODE_ADJ) begin
                    if (nbr_rd_reg == target_reg) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_Q_PHASE;
                    end
                end else if (half_reg == 2'd2) begin
                    // The mark of this neighbor is fetched for the count.
                    state_next = S_Q_MCHK;
                end else begin
                    // Phase 1 sets the mark, phase 3 clears it.
                    mark_we = 1'b1;
                    mark_wdata = (half_reg == 2'd1);
                    state_next = S_Q_PHASE;
                end
            end
            S_Q_MCHK: state_next = S_Q_PHASE;
            S_DONE: begin
                if (!out_valid_reg) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLR;
            edge_total_reg  <= '0;
            built_reg       <= 1'b0;
            vcount_reg      <= CountWidth'(1024);
            busy_reg        <= 1'b1;
            out_valid_reg   <= 1'b0;
            idx_reg         <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                vcount_reg <= cfg_data;
                built_reg  <= 1'b0;
            end
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (s_valid && s_ready) begin
                item_reg <= s_data;
                busy_reg <= 1'b1;
                idx_reg  <= '0;
                sum_reg  <= '0;
                half_reg <= '0;
                count_reg <= '0;
                deg_a_valid_reg <= 1'b0;
                work_reg.answer <= '0;
                work_reg.status <= ST_OK;
            end
            case (state_reg)
                S_CLR: begin
                    if (32'(idx_reg) + 1 >= MAX_VERTICES) begin
                        idx_reg  <= '0;
                        busy_reg <= 1'b0;
                    end else begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                end
                S_IDLE: begin
                    if (busy_reg) begin
                        case (item_reg.mode)
                            MODE_ADD: begin
                                if (!(a_in && b_in)) begin
                                    work_reg.status <= ST_RANGE;
                                end else if (item_reg.vertex_a == item_reg.vertex_b) begin
                                    work_reg.status <= ST_LOOP;
                                end else if (32'(edge_total_reg) >= MAX_EDGES) begin
                                    work_reg.status <= ST_FULL;
                                end else begin
                                    edge_total_reg <= edge_total_reg + ECW'(1);
                                    built_reg <= 1'b0;
                                end
                            end
                            MODE_ADJ, MODE_COMMON: begin
                                if (!(a_in && b_in)) begin
                                    work_reg.status <= ST_RANGE;
                                end else if (!built_reg) begin
                                    work_reg.status <= ST_UNBUILT;
                                end
                            end
                            MODE_CLEAR: begin
                                edge_total_reg <= '0;
                                built_reg <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_BZERO: begin
                    if (32'(idx_reg) + 1 >= 32'(vc)) begin
                        idx_reg <= '0;
                    end else begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                end
                S_BCNT_RD, S_BSC_RD: begin
                    half_reg <= '0;
                    // The edge walk is over; the next pass starts at vertex zero.
                    if (32'(idx_reg) >= 32'(edge_total_reg)) begin
                        idx_reg <= '0;
                    end
                end
                S_BCNT_W, S_BSC_W: begin
                    if (!edge_ok) begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                end
                S_BCNT_WB, S_BSC_WB: begin
                    half_reg <= half_reg + 2'd1;
                    if (half_reg[0]) begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                end
                S_BPFX_W: begin
                    sum_reg <= sum_reg + deg_rd_reg;
                    if (32'(idx_reg) + 1 >= 32'(vc)) begin
                        idx_reg <= '0;
                    end else begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                end
                S_Q_ADDR: begin
                    if (!deg_a_valid_reg) begin
                        deg_a_valid_reg <= 1'b1;
                        deg_a_reg <= deg_rd_reg;
                        off_a_reg <= off_rd_reg;
                    end else begin
                        pos_reg <= '0;
                        if (item_reg.mode == MODE_ADJ) begin
                            half_reg <= 2'd3;
                            if (item_reg.vertex_a == item_reg.vertex_b) begin
                                len_reg <= '0;
                            end else if (deg_a_reg < deg_rd_reg) begin
                                base_reg <= off_a_reg; len_reg <= deg_a_reg;
                                target_reg <= VW'(item_reg.vertex_b);
                            end else begin
                                base_reg <= off_rd_reg; len_reg <= deg_rd_reg;
                                target_reg <= VW'(item_reg.vertex_a);
                            end
                        end else if (item_reg.vertex_a == item_reg.vertex_b) begin
                            half_reg <= 2'd3;
                            len_reg <= '0;
                            count_reg <= AnswerWidth'(deg_a_reg);
                            work_reg.answer <= AnswerWidth'(deg_a_reg);
                        end else begin
                            // Phase 1 marks vertex_a's neighbors.
                            half_reg <= 2'd1;
                            base_reg <= off_a_reg; len_reg <= deg_a_reg;
                            deg_a_reg <= deg_rd_reg;
                            sum_reg <= off_rd_reg;
                        end
                    end
                end
                S_Q_PHASE: begin
                    if (pos_reg >= len_reg && item_reg.mode == MODE_COMMON
                            && half_reg != 2'd3) begin
                        pos_reg <= '0;
                        half_reg <= half_reg + 2'd1;
                        if (half_reg == 2'd1) begin
                            // Phase 2 counts marks over vertex_b's list.
                            off_a_reg <= base_reg;
                            deg_a_valid_reg <= 1'b1;
                            base_reg <= sum_reg; len_reg <= deg_a_reg;
                            deg_a_reg <= len_reg;
                        end else begin
                            // Phase 3 clears the marks again.
                            base_reg <= off_a_reg; len_reg <= deg_a_reg;
                        end
                    end
                end
                S_Q_NCHK: begin
                    pos_reg <= pos_reg + NW'(1);
                    if (item_reg.mode == MODE_ADJ) begin
                        if (nbr_rd_reg == target_reg) begin
                            work_reg.answer <= AnswerWidth'(1);
                        end
                    end
                end
                S_Q_MCHK: begin
                    if (mark_rd_reg) begin
                        count_reg <= count_reg + AnswerWidth'(1);
                        work_reg.answer <= count_reg + AnswerWidth'(1);
                    end
                end
                S_DONE: begin
                    if (!out_valid_reg) begin
                        out_valid_reg <= 1'b1;
                        out_reg <= work_reg;
                        busy_reg <= 1'b0;
                        if (item_reg.mode == MODE_BUILD) begin
                            built_reg <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== bench/graph_adjacency_engine_unit_test.sv =====
// Self-checking testbench for the graph adjacency engine: graph building, queries and flow control.
`timescale 1ns / 100ps

module graph_adjacency_engine_unit_test;
    import gae_pkg::*;

    localparam int unsigned MaxVertices = 1024;
    localparam int unsigned MaxEdges    = 4096;
    // The longest stretch with no transfer is a build over about 1300 stored
    // edges, so the idle limit leaves a wide margin above that.
    localparam int unsigned IdleLimit   = 150000;
    localparam int unsigned SettleCycles = 40;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    gae_in_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    gae_out_t              m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CountWidth-1:0] cfg_data;

    graph_adjacency_engine_unit #(
        .MAX_VERTICES(MaxVertices),
        .MAX_EDGES   (MaxEdges)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Shadow copy of the engine's graph. The edge store and the compressed
    // rows are rebuilt here exactly as the engine is expected to do it.
    logic [VertexIdWidth-1:0] edge_src [MaxEdges];
    logic [VertexIdWidth-1:0] edge_dst [MaxEdges];
    int unsigned              stored_edges;
    int unsigned              row_degree [MaxVertices];
    int unsigned              row_start  [MaxVertices + 1];
    int unsigned              row_fill   [MaxVertices];
    logic [VertexIdWidth-1:0] neighbors  [2 * MaxEdges];
    bit                       seen_mark  [MaxVertices];
    bit                       graph_built;
    logic [CountWidth-1:0]    vertex_count_reg;

    gae_out_t pending_results[$];
    int unsigned error_count;
    int unsigned idle_cycles;

    // Flow-control knobs shared by the test tasks and the drivers.
    bit          steady_flow;
    int unsigned receiver_holdoff;

    // The register is saturated into 1..MaxVertices before use.
    function automatic int unsigned live_vertex_count();
        if (vertex_count_reg < 1) return 1;
        if (vertex_count_reg > MaxVertices) return MaxVertices;
        return vertex_count_reg;
    endfunction

    function automatic bit edge_usable(int unsigned j, int unsigned vc);
        return edge_src[j] < vc && edge_dst[j] < vc && edge_src[j] != edge_dst[j];
    endfunction

    // Degree count, prefix sum of row starts, then scatter of both endpoints.
    function automatic void rebuild_rows();
        int unsigned vc;
        int unsigned total;
        vc = live_vertex_count();
        total = 0;
        for (int unsigned u = 0; u < vc; u++) row_degree[u] = 0;
        for (int unsigned j = 0; j < stored_edges; j++) begin
            if (edge_usable(j, vc)) begin
                row_degree[edge_src[j]]++;
                row_degree[edge_dst[j]]++;
            end
        end
        for (int unsigned u = 0; u < vc; u++) begin
            row_start[u] = total;
            total += row_degree[u];
            row_fill[u] = 0;
        end
        row_start[vc] = total;
        for (int unsigned j = 0; j < stored_edges; j++) begin
            if (edge_usable(j, vc)) begin
                neighbors[row_start[edge_src[j]] + row_fill[edge_src[j]]] = edge_dst[j];
                row_fill[edge_src[j]]++;
                neighbors[row_start[edge_dst[j]] + row_fill[edge_dst[j]]] = edge_src[j];
                row_fill[edge_dst[j]]++;
            end
        end
        graph_built = 1'b1;
    endfunction

    function automatic int unsigned adjacency_flag(int unsigned a, int unsigned b);
        int unsigned owner;
        int unsigned target;
        if (a == b) return 0;
        owner = b;
        target = a;
        if (row_degree[a] < row_degree[b]) begin
            owner = a;
            target = b;
        end
        for (int unsigned i = 0; i < row_degree[owner]; i++)
            if (neighbors[row_start[owner] + i] == target) return 1;
        return 0;
    endfunction

    // Duplicate neighbors of b each count once if they are neighbors of a.
    function automatic int unsigned shared_neighbor_count(int unsigned a, int unsigned b);
        int unsigned total;
        if (a == b) return row_degree[a];
        total = 0;
        for (int unsigned i = 0; i < row_degree[a]; i++) seen_mark[neighbors[row_start[a] + i]] = 1;
        for (int unsigned i = 0; i < row_degree[b]; i++)
            if (seen_mark[neighbors[row_start[b] + i]]) total++;
        for (int unsigned i = 0; i < row_degree[a]; i++) seen_mark[neighbors[row_start[a] + i]] = 0;
        return total;
    endfunction

    // Applies one accepted item to the shadow graph and returns its result.
    function automatic gae_out_t graph_step(gae_in_t item);
        gae_out_t    res;
        int unsigned vc;
        vc = live_vertex_count();
        res = '0;
        res.status = ST_OK;
        case (item.mode)
            MODE_ADD: begin
                if (item.vertex_a >= vc || item.vertex_b >= vc) res.status = ST_RANGE;
                else if (item.vertex_a == item.vertex_b) res.status = ST_LOOP;
                else if (stored_edges >= MaxEdges) res.status = ST_FULL;
                else begin
                    edge_src[stored_edges] = item.vertex_a;
                    edge_dst[stored_edges] = item.vertex_b;
                    stored_edges++;
                    graph_built = 1'b0;
                end
            end
            MODE_BUILD: rebuild_rows();
            MODE_ADJ, MODE_COMMON: begin
                if (item.vertex_a >= vc || item.vertex_b >= vc) res.status = ST_RANGE;
                else if (!graph_built) res.status = ST_UNBUILT;
                else if (item.mode == MODE_ADJ)
                    res.answer = AnswerWidth'(adjacency_flag(item.vertex_a, item.vertex_b));
                else
                    res.answer = AnswerWidth'(shared_neighbor_count(item.vertex_a, item.vertex_b));
            end
            MODE_CLEAR: begin
                stored_edges = 0;
                graph_built = 1'b0;
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // Sends one item; it is predicted at the edge where the transfer happens.
    // Random gaps are inserted before raising valid unless steady flow is on.
    task automatic send_item(input gae_in_t item);
        @(negedge aclk);
        while (!steady_flow && $urandom_range(99) < 34) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!(s_valid && s_ready));
        pending_results.push_back(graph_step(item));
    endtask

    task automatic send_fields(input logic [ModeWidth-1:0] mode,
                               input int unsigned a, input int unsigned b);
        gae_in_t item;
        item.mode     = mode;
        item.vertex_a = VertexIdWidth'(a);
        item.vertex_b = VertexIdWidth'(b);
        send_item(item);
    endtask

    // Lowers valid, then waits until every expected result has come back and
    // lets the engine settle before anything else happens.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    // The count register is only written with the engine idle.
    task automatic write_vertex_count(input int unsigned value);
        drain_results();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= CountWidth'(value);
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        vertex_count_reg = CountWidth'(value);
        graph_built = 1'b0;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Result receiver: random stalls, a forced hold-off when requested, and
    // no stalls at all while steady flow is on.
    always @(negedge aclk) begin
        if (receiver_holdoff > 0) begin
            m_ready <= 1'b0;
            receiver_holdoff <= receiver_holdoff - 1;
        end else if (steady_flow) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= 34);
        end
    end

    // Compares every result transfer with the oldest expectation.
    always @(posedge aclk) begin
        gae_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result answer=%0d status=%0d",
                                          m_data.answer, m_data.status));
            end else begin
                want = pending_results.pop_front();
                if (m_data.answer !== want.answer)
                    report_mismatch($sformatf("answer %0d, wanted %0d",
                                              m_data.answer, want.answer));
                if (m_data.status !== want.status)
                    report_mismatch($sformatf("status %0d, wanted %0d",
                                              m_data.status, want.status));
            end
        end
    end

    // Watchdog: any transfer on any channel counts as progress.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("[graph_adjacency_engine_unit] ERROR");
                $finish;
            end
        end
    end

    // Extremes, every mode, duplicates, self loops, equal query vertices,
    // queries before a build, clear and the unused modes.
    task automatic test_directed_cases();
        send_fields(MODE_ADJ, 0, 1);
        send_fields(MODE_COMMON, 1023, 0);
        send_fields(MODE_ADD, 0, 1);
        send_fields(MODE_ADD, 1, 2);
        send_fields(MODE_ADD, 0, 2);
        send_fields(MODE_ADD, 1, 0);
        send_fields(MODE_ADD, 3, 3);
        send_fields(MODE_ADD, 1023, 0);
        send_fields(MODE_ADD, 1023, 2);
        send_fields(MODE_BUILD, 1023, 1023);
        send_fields(MODE_ADJ, 0, 1);
        send_fields(MODE_ADJ, 1, 0);
        send_fields(MODE_ADJ, 0, 3);
        send_fields(MODE_ADJ, 2, 2);
        send_fields(MODE_COMMON, 0, 1);
        send_fields(MODE_COMMON, 0, 0);
        send_fields(MODE_COMMON, 1023, 1);
        send_fields(MODE_COMMON, 1023, 1023);
        send_fields(3'd5, 1023, 1023);
        send_fields(3'd6, 0, 0);
        send_fields(3'd7, 512, 1);
        send_fields(MODE_CLEAR, 0, 0);
        send_fields(MODE_ADJ, 0, 1);
        drain_results();
    endtask

    // Register extremes: zero saturates to one vertex, large values to the
    // maximum; a shrunken count makes build skip edges that no longer fit.
    task automatic test_vertex_count_limits();
        write_vertex_count(0);
        send_fields(MODE_ADD, 0, 0);
        send_fields(MODE_ADD, 0, 1);
        send_fields(MODE_BUILD, 0, 0);
        send_fields(MODE_COMMON, 0, 0);
        send_fields(MODE_ADJ, 0, 1);
        write_vertex_count(2047);
        send_fields(MODE_ADD, 900, 4);
        send_fields(MODE_ADD, 1, 4);
        send_fields(MODE_ADD, 2, 4);
        send_fields(MODE_BUILD, 0, 0);
        send_fields(MODE_COMMON, 1, 900);
        write_vertex_count(5);
        send_fields(MODE_COMMON, 1, 2);
        send_fields(MODE_BUILD, 0, 0);
        send_fields(MODE_COMMON, 1, 2);
        send_fields(MODE_COMMON, 4, 4);
        send_fields(MODE_ADD, 7, 1);
        send_fields(MODE_ADJ, 900, 4);
        write_vertex_count(1);
        write_vertex_count(1024);
        send_fields(MODE_CLEAR, 0, 0);
        drain_results();
    endtask

    // Loads a dense graph on few vertices without stalls, builds it once and
    // queries it.
    task automatic test_large_graph();
        int unsigned a;
        int unsigned b;
        write_vertex_count(64);
        steady_flow = 1'b1;
        for (int unsigned n = 0; n < 600; n++) begin
            a = $urandom_range(63);
            b = (a + 1 + $urandom_range(62)) % 64;
            send_fields(MODE_ADD, a, b);
        end
        steady_flow = 1'b0;
        send_fields(MODE_ADD, 5, 5);
        send_fields(MODE_ADD, 64, 6);
        send_fields(MODE_BUILD, 0, 0);
        for (int unsigned n = 0; n < 6; n++)
            send_fields($urandom_range(1) ? MODE_ADJ : MODE_COMMON,
                        $urandom_range(63), $urandom_range(63));
        send_fields(MODE_CLEAR, 0, 0);
        drain_results();
    endtask

    // Mostly well-formed rounds: a graph of random edges, a build and a mix of
    // queries, with out-of-range vertices, self loops, unused modes and
    // late edges that leave the graph unbuilt as noise.
    task automatic random_round(input int unsigned vc);
        int unsigned edges_to_add;
        int unsigned queries;
        int unsigned a;
        int unsigned b;
        int unsigned pick;
        if ($urandom_range(3) == 0) send_fields(MODE_CLEAR, $urandom, $urandom);
        edges_to_add = $urandom_range(40, 4);
        for (int unsigned n = 0; n < edges_to_add; n++) begin
            pick = $urandom_range(99);
            if (pick < 8) send_fields(MODE_ADD, $urandom, $urandom);
            else if (pick < 14) begin
                a = $urandom_range(vc - 1);
                send_fields(MODE_ADD, a, a);
            end else
                send_fields(MODE_ADD, $urandom_range(vc - 1), $urandom_range(vc - 1));
        end
        send_fields(MODE_BUILD, $urandom, $urandom);
        queries = $urandom_range(40, 10);
        for (int unsigned n = 0; n < queries; n++) begin
            pick = $urandom_range(99);
            a = $urandom_range(vc - 1);
            b = ($urandom_range(5) == 0) ? a : $urandom_range(vc - 1);
            if (pick < 42) send_fields(MODE_ADJ, a, b);
            else if (pick < 84) send_fields(MODE_COMMON, a, b);
            else if (pick < 90)
                send_fields(ModeWidth'($urandom_range(3, 2)), $urandom, $urandom);
            else if (pick < 94)
                send_fields(ModeWidth'($urandom_range(7, 5)), $urandom, $urandom);
            else send_fields(MODE_ADD, $urandom_range(vc - 1), $urandom_range(vc - 1));
        end
    endtask

    task automatic test_random_graphs();
        int unsigned vc;
        for (int unsigned round = 0; round < 16; round++) begin
            if (round % 4 == 0) begin
                case ($urandom_range(7))
                    0:       vc = 1024;
                    1:       vc = $urandom_range(4, 2);
                    default: vc = $urandom_range(64, 6);
                endcase
                write_vertex_count(vc);
            end
            // One stretch of rounds runs with neither side idling.
            steady_flow = (round >= 10 && round < 13);
            random_round(vc);
        end
        steady_flow = 1'b0;
        drain_results();
    endtask

    // The receiver holds off for a long stretch while items keep coming, so
    // the engine fills and stalls its input; then the sender waits for all
    // results before continuing.
    task automatic test_result_backpressure();
        write_vertex_count(16);
        for (int unsigned n = 0; n < 12; n++)
            send_fields(MODE_ADD, n, n + 1);
        send_fields(MODE_BUILD, 0, 0);
        drain_results();
        @(negedge aclk);
        receiver_holdoff = 400;
        for (int unsigned n = 0; n < 12; n++)
            send_fields(n % 2 ? MODE_ADJ : MODE_COMMON, $urandom_range(15), $urandom_range(15));
        drain_results();
        for (int unsigned n = 0; n < 8; n++)
            send_fields(MODE_COMMON, $urandom_range(15), $urandom_range(15));
        drain_results();
    endtask

    initial begin
        aclk             = 1'b0;
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_data           = '0;
        m_ready          = 1'b0;
        cfg_valid        = 1'b0;
        cfg_data         = '0;
        stored_edges     = 0;
        graph_built      = 1'b0;
        vertex_count_reg = CountWidth'(MaxVertices);
        error_count      = 0;
        idle_cycles      = 0;
        steady_flow      = 1'b0;
        receiver_holdoff = 0;
        for (int unsigned v = 0; v < MaxVertices; v++) seen_mark[v] = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed_cases();
        test_vertex_count_limits();
        test_result_backpressure();
        test_random_graphs();
        test_large_graph();

        drain_results();
        if (error_count == 0) begin
            $display("[graph_adjacency_engine_unit] OK");
        end else begin
            $display("[graph_adjacency_engine_unit] ERROR");
        end
        $finish;
    end

endmodule
